// ===== hdl/tsw_pkg.sv =====
// package: widths, codes and helpers for the texture sampler
`timescale 1ns / 1ps
package tsw_pkg;
    localparam int MAX_WIDTH       = 256;
    localparam int MAX_HEIGHT      = 256;
    localparam int COORD_FRAC_BITS = 16;
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int AW   = XW + YW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int SZW  = 9;
    localparam int FB   = COORD_FRAC_BITS;
    localparam int TW   = FB + 1;
    localparam int CW   = 24;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BORDER = 2'd2;
    localparam logic [1:0] REG_FILTER = 2'd3;

    localparam logic [1:0] BM_REPEAT = 2'd0;
    localparam logic [1:0] BM_MIRROR = 2'd1;
    localparam logic [1:0] BM_CLAMP  = 2'd2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic [SZW-1:0] w;
        logic [SZW-1:0] h;
        logic [1:0]     border;
        logic           filter;
    } t_cfg;

    function automatic logic [TW-1:0] reduce(input logic [1:0] bm,
                                             input logic signed [CW-1:0] c);
        logic [TW-1:0] one;
        logic [TW-1:0] fr;
        begin
            one = TW'(1) << FB;
            fr  = {1'b0, c[FB-1:0]};
            reduce = fr;
            if (bm == BM_CLAMP) begin
                if (c < 0) reduce = '0;
                else if (c > $signed({{(CW-TW){1'b0}}, one})) reduce = one;
                else reduce = c[TW-1:0];
            end else if (bm == BM_MIRROR && c[FB]) begin
                reduce = one - fr;
            end
        end
    endfunction
endpackage

// ===== hdl/tsw_ram.sv =====
// generic single write, single registered read memory
`timescale 1ns / 1ps
module tsw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_q <= r_mem[i_raddr];
    end
    assign o_rdata = r_q;
endmodule

// ===== hdl/tsw_addr.sv =====
// address stages: border reduction, scaling, neighbor coordinates
`timescale 1ns / 1ps
module tsw_addr import tsw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_cfg                 i_cfg,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_u,
    input  logic signed [CW-1:0] i_v,
    output logic                 o_valid,
    output logic [XW-1:0]        o_x0,
    output logic [XW-1:0]        o_x1,
    output logic [YW-1:0]        o_y0,
    output logic [YW-1:0]        o_y1,
    output logic [FB:0]          o_fx,
    output logic [FB:0]          o_fy
);
    logic           r_v1, r_v2;
    logic [TW-1:0]  r_tu, r_tv;
    logic [SZW-1:0] r_mu, r_mv, r_lu, r_lv;
    logic           r_bil;
    logic [TW+SZW-1:0] n_su, n_sv;
    logic [TW+SZW-1:0] su, sv;
    logic [SZW-1:0] wc, hc;
    logic [SZW-1:0] xi, yi;

    always_comb begin
        wc = (i_cfg.w == '0) ? SZW'(1) : (i_cfg.w > SZW'(MAX_WIDTH)) ? SZW'(MAX_WIDTH) : i_cfg.w;
        hc = (i_cfg.h == '0) ? SZW'(1) : (i_cfg.h > SZW'(MAX_HEIGHT)) ? SZW'(MAX_HEIGHT)
                                                                      : i_cfg.h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tu  <= reduce(i_cfg.border, i_u);
            r_tv  <= reduce(i_cfg.border, i_v);
            r_bil <= i_cfg.filter;
            r_mu  <= i_cfg.filter ? wc - SZW'(1) : wc;
            r_mv  <= i_cfg.filter ? hc - SZW'(1) : hc;
            r_lu  <= wc - SZW'(1);
            r_lv  <= hc - SZW'(1);
        end
    end

    assign n_su = TW'(r_tu) * r_mu;
    assign n_sv = TW'(r_tv) * r_mv;

    logic [TW+SZW-1:0] r_su, r_sv;
    logic [SZW-1:0]    r_lu2, r_lv2;
    logic              r_bil2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_su <= n_su; r_sv <= n_sv;
            r_lu2 <= r_lu; r_lv2 <= r_lv; r_bil2 <= r_bil;
        end
    end

    always_comb begin
        su = r_su;
        sv = r_sv;
        xi = su[FB +: SZW];
        yi = sv[FB +: SZW];
        if (!r_bil2) begin
            if (xi > r_lu2) xi = r_lu2;
            if (yi > r_lv2) yi = r_lv2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_en) o_valid <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x0 <= xi[XW-1:0];
            o_y0 <= yi[YW-1:0];
            o_x1 <= xi[XW-1:0] + XW'(r_bil2 && su[FB-1:0] != '0);
            o_y1 <= yi[YW-1:0] + YW'(r_bil2 && sv[FB-1:0] != '0);
            o_fx <= r_bil2 ? {1'b0, su[FB-1:0]} : '0;
            o_fy <= r_bil2 ? {1'b0, sv[FB-1:0]} : '0;
        end
    end
endmodule

// ===== hdl/tsw_blend.sv =====
// blend stages: weights, products, sum and rounding
`timescale 1ns / 1ps
module tsw_blend import tsw_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [FB:0]   i_fx,
    input  logic [FB:0]   i_fy,
    input  logic [CW-1:0] i_c00,
    input  logic [CW-1:0] i_c01,
    input  logic [CW-1:0] i_c10,
    input  logic [CW-1:0] i_c11,
    output logic          o_valid,
    output logic [CW-1:0] o_col
);
    localparam int WW = 2 * FB + 1;
    localparam int PW = WW + 8;
    localparam int SW = PW + 2;
    logic [FB:0] one;
    assign one = (FB + 1)'(1) << FB;

    logic          r_v1, r_v2;
    logic [WW-1:0] r_w [4];
    logic [CW-1:0] r_c [4];
    logic [PW-1:0] r_p [4][3];
    logic [SW-1:0] sum [3];
    logic [SW-1:0] rs  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w[0] <= WW'(one - i_fx) * WW'(one - i_fy);
            r_w[1] <= WW'(one - i_fx) * WW'(i_fy);
            r_w[2] <= WW'(i_fx) * WW'(one - i_fy);
            r_w[3] <= WW'(i_fx) * WW'(i_fy);
            r_c[0] <= i_c00; r_c[1] <= i_c01; r_c[2] <= i_c10; r_c[3] <= i_c11;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++)
                for (int c = 0; c < 3; c++)
                    r_p[k][c] <= PW'(r_w[k]) * PW'(r_c[k][8*c +: 8]);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = SW'(r_p[0][c]) + SW'(r_p[1][c]) + SW'(r_p[2][c]) + SW'(r_p[3][c])
                   + (SW'(1) << (2*FB-1));
            rs[c]  = sum[c] >> (2*FB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++)
                o_col[8*c +: 8] <= (rs[c] > SW'(255)) ? 8'hff : rs[c][7:0];
        end
    end
endmodule

// ===== hdl/texture_sampler_wrap_bilinear_unit.sv =====
// texture sampler top level: config, texel store banks, pipeline, output skid
`timescale 1ns / 1ps
// a sample beat passes the address stages, the texel store read, the blend stages and the output register in order
// one beat accepted per cycle while the skid slot is empty; a load writes at the read stage and gives no result
// four copies of the texel store serve the four neighbor reads in one cycle
// reset (synchronous, active low) loads the default config (256 by 256, repeat, filter off) and clears valid bits;
// texels stay undefined; no clearing pass: the user must load a texel before it is read, the block does not enforce it
module texture_sampler_wrap_bilinear_unit import tsw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind, texel_x, texel_y, load_red, load_green, load_blue, coord_u, coord_v, pad
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0] m_axis_tdata
);
    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{w: SZW'(256), h: SZW'(256), border: BM_REPEAT, filter: 1'b0};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_cfg.w <= i_cfg_data;
                REG_HEIGHT: r_cfg.h <= i_cfg_data;
                REG_BORDER: r_cfg.border <= i_cfg_data[1:0];
                REG_FILTER: r_cfg.filter <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    logic kind;
    logic [7:0] tx, ty;
    logic [CW-1:0] ldcol;
    logic signed [CW-1:0] cu, cv;
    assign kind  = s_axis_tdata[0];
    assign tx    = s_axis_tdata[8:1];
    assign ty    = s_axis_tdata[16:9];
    assign ldcol = {s_axis_tdata[24:17], s_axis_tdata[32:25], s_axis_tdata[40:33]};
    assign cu    = s_axis_tdata[64:41];
    assign cv    = s_axis_tdata[88:65];

    logic acc, we;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign we  = acc && kind == KIND_LOAD;
    assign s_axis_tready = en;

    logic          a_valid;
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic [FB:0]   fx, fy;

    tsw_addr u_addr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_cfg(r_cfg),
        .i_valid(acc && kind == KIND_SAMPLE), .i_u(cu), .i_v(cv),
        .o_valid(a_valid), .o_x0(x0), .o_x1(x1), .o_y0(y0), .o_y1(y1),
        .o_fx(fx), .o_fy(fy)
    );

    logic [AW-1:0] waddr;
    logic [AW-1:0] ra [4];
    logic [CW-1:0] rd [4];
    assign waddr = {ty[YW-1:0], tx[XW-1:0]};
    assign ra[0] = {y0, x0};
    assign ra[1] = {y1, x0};
    assign ra[2] = {y0, x1};
    assign ra[3] = {y1, x1};

    // loads travel with the address stages so writes and reads keep beat order
    logic          r_lw1, r_lw2, r_lw3;
    logic [AW-1:0] r_la1, r_la2, r_la3;
    logic [CW-1:0] r_lc1, r_lc2, r_lc3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw1 <= 1'b0; r_lw2 <= 1'b0; r_lw3 <= 1'b0;
        end else if (en) begin
            r_lw1 <= we; r_lw2 <= r_lw1; r_lw3 <= r_lw2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_la1 <= waddr; r_la2 <= r_la1; r_la3 <= r_la2;
            r_lc1 <= ldcol; r_lc2 <= r_lc1; r_lc3 <= r_lc2;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        tsw_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram (
            .i_clk(i_clk), .i_we(r_lw3 && en), .i_waddr(r_la3), .i_wdata(r_lc3),
            .i_re(en), .i_raddr(ra[g]), .o_rdata(rd[g])
        );
    end

    logic          r_mv;
    logic [FB:0]   r_fx, r_fy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mv <= 1'b0;
        else if (en) r_mv <= a_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx <= fx; r_fy <= fy;
        end
    end

    logic          b_valid;
    logic [CW-1:0] b_col;
    tsw_blend u_blend (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_mv),
        .i_fx(r_fx), .i_fy(r_fy), .i_c00(rd[0]), .i_c01(rd[1]),
        .i_c10(rd[2]), .i_c11(rd[3]), .o_valid(b_valid), .o_col(b_col)
    );

    // output register plus skid slot
    logic          r_ov, r_sv;
    logic [CW-1:0] r_od, r_sd;
    assign en = !r_sv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_sv <= 1'b0;
        end else begin
            if (!r_ov || m_axis_tready) begin
                if (r_sv) begin
                    r_ov <= 1'b1; r_sv <= 1'b0;
                end else begin
                    r_ov <= b_valid && en;
                end
            end else if (b_valid && en) begin
                r_sv <= 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!r_ov || m_axis_tready) begin
            r_od <= r_sv ? r_sd : b_col;
        end else if (b_valid && en) begin
            r_sd <= b_col;
        end
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_od[7:0], r_od[15:8], r_od[23:16]};
endmodule

// ===== hdl/tsw_checker.sv =====
// port checker for the texture sampler, bound to the top level
`timescale 1ns / 1ps
module tsw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |=> s_axis_tready)
        else $error("input stalled although output drains");
endmodule

bind texture_sampler_wrap_bilinear_unit tsw_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== bench/texture_sampler_wrap_bilinear_unit_tb.sv =====
// testbench: texture sampler checked against a built-in predictor under random flow control
`timescale 1ns / 1ps
module texture_sampler_wrap_bilinear_unit_tb;
    import tsw_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [7:0]        tx;
        logic [7:0]        ty;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        logic signed [23:0] u;
        logic signed [23:0] v;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // kind, texel_x, texel_y, load_red, load_green, load_blue, coord_u, coord_v, pad
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // out_red, out_green, out_blue
    logic [23:0] m_axis_tdata;

    texture_sampler_wrap_bilinear_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    t_beat       pending_beats[$];
    logic [23:0] expected_colors[$];
    logic [23:0] texels[int];
    int          mdl_w, mdl_h;
    logic [1:0]  mdl_border;
    logic        mdl_filter;
    int          errors;
    int          cycles;
    int          hold_cycles;
    int          gap_left, burst_left, stall_phase;
    bit          sender_on;
    bit          in_taken;

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch %s: got %06h want %06h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [95:0] pack_beat(input t_beat b);
        return {7'd0, b.v, b.u, b.b, b.g, b.r, b.ty, b.tx, b.kind};
    endfunction

    function automatic t_beat unpack_beat(input logic [95:0] d);
        t_beat b;
        b.kind = d[0];
        b.tx   = d[8:1];
        b.ty   = d[16:9];
        b.r    = d[24:17];
        b.g    = d[32:25];
        b.b    = d[40:33];
        b.u    = d[64:41];
        b.v    = d[88:65];
        return b;
    endfunction

    function automatic longint wrap_coord(input logic signed [23:0] c);
        longint one, fr;
        one = 64'd1 << COORD_FRAC_BITS;
        fr  = c[15:0];
        if (mdl_border == BM_CLAMP) begin
            if (c < 0) return 0;
            if (longint'(c) > one) return one;
            return longint'(c);
        end
        if (mdl_border == BM_MIRROR && c[16]) return one - fr;
        return fr;
    endfunction

    function automatic logic [23:0] texel_at(input longint x, input longint y);
        int a;
        a = int'(y) * MAX_WIDTH + int'(x);
        return texels.exists(a) ? texels[a] : 24'd0;
    endfunction

    function automatic logic [23:0] sample_color(input t_beat b);
        longint one, tu, tv, x, y, su, sv, fx, fy, x1, y1, wt[4], s;
        logic [23:0] c[4];
        logic [23:0] res;
        one = 64'd1 << COORD_FRAC_BITS;
        tu = wrap_coord(b.u);
        tv = wrap_coord(b.v);
        if (!mdl_filter) begin
            x = (tu * mdl_w) >> COORD_FRAC_BITS;
            y = (tv * mdl_h) >> COORD_FRAC_BITS;
            if (x > mdl_w - 1) x = mdl_w - 1;
            if (y > mdl_h - 1) y = mdl_h - 1;
            return texel_at(x, y);
        end
        su = tu * (mdl_w - 1);
        sv = tv * (mdl_h - 1);
        x = su >> COORD_FRAC_BITS;
        y = sv >> COORD_FRAC_BITS;
        fx = su & (one - 1);
        fy = sv & (one - 1);
        x1 = x + (fx != 0);
        y1 = y + (fy != 0);
        wt[0] = (one - fx) * (one - fy); c[0] = texel_at(x, y);
        wt[1] = (one - fx) * fy;         c[1] = texel_at(x, y1);
        wt[2] = fx * (one - fy);         c[2] = texel_at(x1, y);
        wt[3] = fx * fy;                 c[3] = texel_at(x1, y1);
        for (int ch = 0; ch < 3; ch++) begin
            s = 0;
            for (int k = 0; k < 4; k++) s += wt[k] * ((c[k] >> (8 * ch)) & 8'hff);
            s = (s + (64'd1 << (2 * COORD_FRAC_BITS - 1))) >> (2 * COORD_FRAC_BITS);
            res[8*ch +: 8] = s > 255 ? 8'd255 : s[7:0];
        end
        return res;
    endfunction

    // predictor, run on acceptance
    task automatic predict(input t_beat b);
        if (b.kind == KIND_LOAD) texels[int'(b.ty) * MAX_WIDTH + int'(b.tx)] = {b.r, b.g, b.b};
        else expected_colors.push_back(sample_color(b));
    endtask

    // driver: bursts and gaps, pause on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (!sender_on || pending_beats.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tdata  <= pack_beat(pending_beats.pop_front());
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
                end
            end
        end
    end

    t_beat accepted;
    always @(posedge i_clk) begin
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            accepted = unpack_beat(s_axis_tdata);
            predict(accepted);
        end
    end

    // receiver stall pattern plus long hold-off
    always @(negedge i_clk) begin
        stall_phase = (stall_phase + 1) % 23;
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end else if (stall_phase < 8) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, 24'd0);
            end else begin
                logic [23:0] want;
                want = expected_colors.pop_front();
                // port order: red in the lowest byte
                want = {want[7:0], want[15:8], want[23:16]};
                if (m_axis_tdata[7:0] != want[7:0])
                    report_mismatch("out_red", m_axis_tdata, want);
                if (m_axis_tdata[15:8] != want[15:8])
                    report_mismatch("out_green", m_axis_tdata, want);
                if (m_axis_tdata[23:16] != want[23:16])
                    report_mismatch("out_blue", m_axis_tdata, want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_WIDTH:  mdl_w = (val == 0) ? 1 : (val > MAX_WIDTH ? MAX_WIDTH : int'(val));
            REG_HEIGHT: mdl_h = (val == 0) ? 1 : (val > MAX_HEIGHT ? MAX_HEIGHT : int'(val));
            REG_BORDER: mdl_border = val[1:0];
            default:    mdl_filter = val[0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic queue_load(input int x, input int y, input logic [23:0] rgb);
        t_beat b;
        b = '0;
        b.kind = KIND_LOAD;
        b.tx = 8'(x); b.ty = 8'(y);
        {b.r, b.g, b.b} = rgb;
        pending_beats.push_back(b);
    endtask

    task automatic queue_sample(input logic [23:0] u, input logic [23:0] v);
        t_beat b;
        b = '0;
        b.kind = KIND_SAMPLE;
        b.u = u; b.v = v;
        b.tx = 8'($urandom); b.ty = 8'($urandom);
        {b.r, b.g, b.b} = 24'($urandom);
        pending_beats.push_back(b);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'h010000;
            3: return 24'($urandom_range(0, 24'h10000));
            default: return 24'($urandom);
        endcase
    endfunction

    // a phase: load the whole used texture first, then samples mixed with some reloads
    task automatic run_phase(input int w, input int h, input logic [1:0] bm,
                             input logic fm, input int n);
        write_reg(REG_WIDTH, 9'(w));
        write_reg(REG_HEIGHT, 9'(h));
        write_reg(REG_BORDER, 9'(bm));
        write_reg(REG_FILTER, 9'(fm));
        for (int y = 0; y < mdl_h; y++)
            for (int x = 0; x < mdl_w; x++) queue_load(x, y, 24'($urandom));
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) queue_load($urandom_range(0, mdl_w - 1),
                                                   $urandom_range(0, mdl_h - 1),
                                                   24'($urandom));
            else queue_sample(rand_coord(), rand_coord());
        end
        sender_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = REG_WIDTH; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        mdl_w = 256; mdl_h = 256; mdl_border = BM_REPEAT; mdl_filter = 1'b0;
        errors = 0; cycles = 0; hold_cycles = 0; gap_left = 0; burst_left = 0;
        stall_phase = 0; sender_on = 1'b1; in_taken = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // directed: corners, extremes of every field, border modes, clamp at one
        write_reg(REG_WIDTH, 9'd2);
        write_reg(REG_HEIGHT, 9'd2);
        queue_load(0, 0, 24'h000000);
        queue_load(1, 0, 24'hffffff);
        queue_load(0, 1, 24'h00ff00);
        queue_load(1, 1, 24'hff00ff);
        queue_load(255, 255, 24'h123456);
        queue_sample(24'h800000, 24'h7fffff);
        queue_sample(24'h010000, 24'h010000);
        queue_sample(24'h008000, 24'h004000);
        queue_sample(24'hffffff, 24'h000000);
        wait_drained();
        for (int bm = 0; bm < 4; bm++) begin
            write_reg(REG_BORDER, 9'(bm));
            for (int fm = 0; fm < 2; fm++) begin
                write_reg(REG_FILTER, 9'(fm));
                queue_sample(24'h010000, 24'h018000);
                queue_sample(24'hff8000, 24'h7fffff);
                wait_drained();
            end
        end
        // sizes 0 and above max clip to 1 and 256
        run_phase(0, 511, BM_CLAMP, 1'b1, 40);
        run_phase(256, 1, BM_MIRROR, 1'b0, 40);
        // long receiver hold-off while the sender keeps offering
        hold_cycles = 200;
        run_phase(5, 7, BM_REPEAT, 1'b1, 150);
        sender_on = 1'b0;
        run_phase(16, 3, BM_MIRROR, 1'b1, 100);
        run_phase(1, 9, BM_CLAMP, 1'b0, 60);
        run_phase(8, 8, 2'd3, 1'b1, 100);
        run_phase(3, 2, BM_CLAMP, 1'b1, 60);
        wait_drained();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/tsw_pkg.sv
hdl/tsw_ram.sv
hdl/tsw_addr.sv
hdl/tsw_blend.sv
hdl/texture_sampler_wrap_bilinear_unit.sv
hdl/tsw_checker.sv
bench/texture_sampler_wrap_bilinear_unit_tb.sv
